### hdl/wpls_pkg.sv
`timescale 1ns / 1ps
package wpls_pkg;

  localparam int WHEELS = 4;
  localparam int LIM_W  = 12;  // adjusted limit, signed watts
  localparam int PWR_W  = 32;  // per wheel power, q16.16 magnitude
  localparam int EST_W  = 34;  // sum over the wheels

  // power model coefficients, scaled by 2^40
  localparam logic signed [40:0] K_CONST  = 41'sd537355092940;
  localparam logic signed [29:0] K_SPEED  = -30'sd322804581;
  localparam logic signed [26:0] K_CURR   = 27'sd58539471;
  localparam logic signed [18:0] K_SPEED2 = 19'sd219902;
  localparam logic signed [22:0] K_CROSS  = 23'sd2242849;
  localparam logic signed [18:0] K_CURR2  = 19'sd137439;

  // classified item handed from the front to the back
  typedef struct packed {
    logic [WHEELS-1:0][15:0] curr;
    logic [WHEELS-1:0][15:0] speed;
    logic [LIM_W-1:0]        lim_adj;
    logic                    lim_zero;
  } cls_t;

endpackage

### hdl/wpls_front.sv
`timescale 1ns / 1ps
module wpls_front #(
  parameter int FRAC = 15
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      acc,
  input  logic [wpls_pkg::WHEELS-1:0][15:0]         curr,
  input  logic [wpls_pkg::WHEELS-1:0][15:0]         speed,
  input  logic [9:0]                                lim,
  input  logic [8:0]                                volt,
  input  logic                                      cap_nf,
  input  logic [15:0]                               meas,
  output logic                                      out_v,
  output wpls_pkg::cls_t                            out_cls,
  output logic signed [FRAC:0]                      out_corr
);

  localparam int CM = ((1 << FRAC) + 5) / 10;
  localparam int XW = FRAC + 18;
  localparam int YW = FRAC + 2;
  localparam int SH = YW + 5;
  localparam int MW = SH - 4;
  localparam int CW = FRAC + 1;
  localparam logic [63:0] RECIP64 = ((64'd1 << SH) + 64'd24) / 64'd25;
  localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];
  localparam logic [63:0] SAT64 = 64'(CM) * 64'd1600;
  localparam logic [XW-1:0] SAT_X = SAT64[XW-1:0];
  localparam logic [CW-1:0] CM_V = CW'(CM);

  // stage 1: captured item
  logic                            v1_r;
  logic [wpls_pkg::WHEELS-1:0][15:0] curr1_r, speed1_r;
  logic [9:0]                      lim1_r;
  logic [8:0]                      volt1_r;
  logic                            nf1_r;
  logic [15:0]                     meas1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      curr1_r  <= curr;
      speed1_r <= speed;
      lim1_r   <= lim;
      volt1_r  <= volt;
      nf1_r    <= cap_nf;
      meas1_r  <= meas;
    end
  end

  // limit adjustment and correction prep
  logic signed [wpls_pkg::LIM_W-1:0] ladj;
  logic signed [17:0]                err;
  logic [17:0]                       m3;
  logic                              cond_nxt;
  logic [16:0]                       ea;
  logic [XW-1:0]                     x;
  logic                              sat_nxt;
  logic [YW-1:0]                     y_nxt;

  always_comb begin
    if ((volt1_r <= 9'd120) || nf1_r) begin
      ladj = $signed({2'b00, lim1_r}) - 12'sd2
           - ((volt1_r <= 9'd100) ? 12'sd2 : 12'sd0)
           - ((volt1_r <= 9'd80) ? 12'sd4 : 12'sd0);
    end else begin
      ladj = $signed({2'b00, lim1_r}) + $signed({3'b000, volt1_r});
    end
    err = $signed({{2{ladj[11]}}, ladj, 4'b0000}) - $signed({2'b00, meas1_r});
    m3 = 18'({2'b00, meas1_r}) * 18'd3;
    cond_nxt = $signed({1'b0, m3}) >= $signed({{3{ladj[11]}}, ladj, 4'b0000});
    ea = err[17] ? 17'(-err) : err[16:0];
    x = XW'({ea, {FRAC{1'b0}}}) + XW'(800);
    sat_nxt = x >= SAT_X;
    y_nxt = x[YW+5:6];
  end

  // stage 2
  logic                  v2_r, cond2_r, neg2_r, sat2_r;
  logic [YW-1:0]         y2_r;
  wpls_pkg::cls_t        cls2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    cls2_r.curr     <= curr1_r;
    cls2_r.speed    <= speed1_r;
    cls2_r.lim_adj  <= ladj;
    cls2_r.lim_zero <= lim1_r == 10'd0;
    cond2_r         <= cond_nxt;
    neg2_r          <= err[17];
    sat2_r          <= sat_nxt;
    y2_r            <= y_nxt;
  end

  // division by 1600 through a reciprocal, clamped to the correction bound
  logic [YW+MW-1:0]      prod;
  logic [CW-1:0]         cmag;
  logic signed [CW-1:0]  corr_nxt;

  always_comb begin
    prod = (YW+MW)'(y2_r) * (YW+MW)'(RECIP);
    cmag = sat2_r ? CM_V : CW'(prod[YW+MW-1:SH]);
    if (!cond2_r) begin
      corr_nxt = '0;
    end else if (neg2_r) begin
      corr_nxt = -$signed(cmag);
    end else begin
      corr_nxt = $signed(cmag);
    end
  end

  // stage 3
  logic                  v3_r;
  wpls_pkg::cls_t        cls3_r;
  logic signed [CW-1:0]  corr3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    cls3_r  <= cls2_r;
    corr3_r <= corr_nxt;
  end

  assign out_v    = v3_r;
  assign out_cls  = cls3_r;
  assign out_corr = corr3_r;

endmodule

### hdl/wpls_queue.sv
`timescale 1ns / 1ps
module wpls_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty,
  output logic         full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign empty   = cnt_r == '0;
  assign full    = cnt_r == (AW+1)'(DEPTH);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

### hdl/wpls_wheel.sv
`timescale 1ns / 1ps
module wpls_wheel (
  input  logic                              clk,
  input  logic signed [15:0]                speed,
  input  logic signed [15:0]                curr,
  output logic [wpls_pkg::PWR_W-1:0]        pwr
);

  logic signed [31:0] ss1_r, sc1_r, cc1_r;
  logic signed [47:0] ls1_r, lc1_r, ls2_r, lc2_r;
  logic signed [55:0] q1_r, q2_r, q3_r;
  logic signed [57:0] t_r;
  logic [57:0]        mag;
  logic [57:0]        rnd;
  logic [wpls_pkg::PWR_W-1:0] p_r;

  // products of the inputs, then by the coefficients
  always_ff @(posedge clk) begin
    ss1_r <= 32'(speed) * 32'(speed);
    sc1_r <= 32'(speed) * 32'(curr);
    cc1_r <= 32'(curr) * 32'(curr);
    ls1_r <= 48'(wpls_pkg::K_SPEED) * 48'(speed);
    lc1_r <= 48'(wpls_pkg::K_CURR) * 48'(curr);
  end

  always_ff @(posedge clk) begin
    q1_r  <= 56'(wpls_pkg::K_SPEED2) * 56'(ss1_r);
    q2_r  <= 56'(wpls_pkg::K_CROSS) * 56'(sc1_r);
    q3_r  <= 56'(wpls_pkg::K_CURR2) * 56'(cc1_r);
    ls2_r <= ls1_r;
    lc2_r <= lc1_r;
  end

  always_ff @(posedge clk) begin
    t_r <= 58'(wpls_pkg::K_CONST) + 58'(ls2_r) + 58'(lc2_r)
         + 58'(q1_r) + 58'(q2_r) + 58'(q3_r);
  end

  // magnitude, rounded half up to q16.16
  always_comb begin
    mag = t_r[57] ? 58'(-t_r) : 58'(t_r);
    rnd = (mag + (58'd1 << 23)) >> 24;
  end

  always_ff @(posedge clk) begin
    p_r <= rnd[wpls_pkg::PWR_W-1:0];
  end

  assign pwr = p_r;

endmodule

### hdl/wpls_div.sv
`timescale 1ns / 1ps
module wpls_div #(
  parameter int FRAC = 15,
  parameter int PW   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_v,
  input  logic [FRAC+26:0]              num,
  input  logic [wpls_pkg::EST_W-1:0]    den,
  input  logic [PW-1:0]                 in_pay,
  output logic                          out_v,
  output logic [FRAC+1:0]               quo,
  output logic                          ovf,
  output logic [PW-1:0]                 out_pay
);

  localparam int QB = FRAC + 2;
  localparam int RW = wpls_pkg::EST_W + QB;

  logic [QB:0]                   v_r;
  logic [RW-1:0]                 rem_r [QB+1];
  logic [wpls_pkg::EST_W-1:0]    den_r [QB+1];
  logic [QB-1:0]                 q_r   [QB+1];
  logic                          ovf_r [QB+1];
  logic [PW-1:0]                 pay_r [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[QB-1:0], in_v};
    end
  end

  // entry: quotient too wide for the bits kept
  always_ff @(posedge clk) begin
    rem_r[0] <= RW'(num);
    den_r[0] <= den;
    q_r[0]   <= '0;
    ovf_r[0] <= RW'(num) >= (RW'(den) << QB);
    pay_r[0] <= in_pay;
  end

  // one quotient bit per stage, msb first
  for (genvar i = 1; i <= QB; i++) begin : g_stage
    localparam int K = QB - i;
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = RW'(den_r[i-1]) << K;
    assign ge = rem_r[i-1] >= sh;
    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? rem_r[i-1] - sh : rem_r[i-1];
      q_r[i]   <= q_r[i-1] | (ge ? (QB'(1) << K) : '0);
      den_r[i] <= den_r[i-1];
      ovf_r[i] <= ovf_r[i-1];
      pay_r[i] <= pay_r[i-1];
    end
  end

  assign out_v   = v_r[QB];
  assign quo     = q_r[QB];
  assign ovf     = ovf_r[QB];
  assign out_pay = pay_r[QB];

endmodule

### hdl/wpls_back.sv
`timescale 1ns / 1ps
module wpls_back #(
  parameter int FRAC = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_v,
  input  wpls_pkg::cls_t                      in_cls,
  input  logic signed [FRAC:0]                in_corr,
  input  logic                                locked,
  output logic                                out_v,
  output logic [15:0]                         out_sf,
  output logic [wpls_pkg::WHEELS-1:0][15:0]   out_drv
);

  localparam int WN  = wpls_pkg::WHEELS;
  localparam int WD  = 4;
  localparam int CW  = FRAC + 1;
  localparam int QB  = FRAC + 2;
  localparam int FW  = FRAC + 4;
  localparam int NW  = FRAC + 27;
  localparam int PW  = WN * 16 + 2 + CW;
  localparam int PRW = FRAC + 18;
  localparam logic [FRAC:0] ONE = {1'b1, {FRAC{1'b0}}};

  // per wheel power pipelines
  logic [WN-1:0][wpls_pkg::PWR_W-1:0] pwr;

  for (genvar i = 0; i < WN; i++) begin : g_wheel
    wpls_wheel u_wheel (
      .clk   (clk),
      .speed ($signed(in_cls.speed[i])),
      .curr  ($signed(in_cls.curr[i])),
      .pwr   (pwr[i])
    );
  end

  // side data alongside the wheel pipelines
  logic [WD-1:0]                  sv_r;
  logic [WN-1:0][15:0]            scurr_r [WD];
  logic [wpls_pkg::LIM_W-1:0]     slim_r  [WD];
  logic                           slz_r   [WD];
  logic signed [CW-1:0]           scorr_r [WD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else begin
      sv_r <= {sv_r[WD-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    scurr_r[0] <= in_cls.curr;
    slim_r[0]  <= in_cls.lim_adj;
    slz_r[0]   <= in_cls.lim_zero;
    scorr_r[0] <= in_corr;
    for (int j = 1; j < WD; j++) begin
      scurr_r[j] <= scurr_r[j-1];
      slim_r[j]  <= slim_r[j-1];
      slz_r[j]   <= slz_r[j-1];
      scorr_r[j] <= scorr_r[j-1];
    end
  end

  // estimate sum
  logic [wpls_pkg::EST_W-1:0]   est_nxt, est_r;
  logic                         v5_r, lz5_r;
  logic [wpls_pkg::LIM_W-1:0]   lim5_r;
  logic signed [CW-1:0]         corr5_r;
  logic [WN-1:0][15:0]          curr5_r;

  always_comb begin
    est_nxt = '0;
    for (int i = 0; i < WN; i++) begin
      est_nxt = est_nxt + wpls_pkg::EST_W'(pwr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= sv_r[WD-1];
    end
  end

  always_ff @(posedge clk) begin
    est_r   <= est_nxt;
    lim5_r  <= slim_r[WD-1];
    lz5_r   <= slz_r[WD-1];
    corr5_r <= scorr_r[WD-1];
    curr5_r <= scurr_r[WD-1];
  end

  // ratio of limit to estimate
  logic                 neg5, one5;
  logic [10:0]          la;
  logic [NW-1:0]        num;
  logic [PW-1:0]        pay;
  logic                 dv, dovf, dneg, done;
  logic [QB-1:0]        dq;
  logic [PW-1:0]        dpay;
  logic [WN-1:0][15:0]  dcurr;
  logic signed [CW-1:0] dcorr;

  always_comb begin
    neg5 = lim5_r[wpls_pkg::LIM_W-1];
    one5 = lz5_r || (est_r == '0);
    la   = neg5 ? 11'(-$signed(lim5_r)) : lim5_r[10:0];
    num  = NW'(la) << (16 + FRAC);
    pay  = {curr5_r, neg5, one5, corr5_r};
  end

  wpls_div #(
    .FRAC (FRAC),
    .PW   (PW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (v5_r),
    .num     (num),
    .den     (est_r),
    .in_pay  (pay),
    .out_v   (dv),
    .quo     (dq),
    .ovf     (dovf),
    .out_pay (dpay)
  );

  assign {dcurr, dneg, done, dcorr} = dpay;

  // factor: signed ratio plus correction, clamped to [0, 1]; 1 for a zero limit or estimate
  logic [QB-1:0]         qs;
  logic signed [FW-1:0]  fq, fsum;
  logic [FRAC:0]         f_nxt;
  logic                  cv_r;
  logic [FRAC:0]         cf_r;
  logic [WN-1:0][15:0]   ccurr_r;

  always_comb begin
    qs   = dovf ? '1 : dq;
    fq   = $signed({2'b00, qs});
    if (dneg) begin
      fq = -fq;
    end
    fsum = fq + FW'(dcorr);
    priority if (done) begin
      f_nxt = ONE;
    end else if (fsum < 0) begin
      f_nxt = '0;
    end else if (fsum > $signed({3'b000, ONE})) begin
      f_nxt = ONE;
    end else begin
      f_nxt = fsum[FRAC:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else begin
      cv_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    cf_r    <= f_nxt;
    ccurr_r <= dcurr;
  end

  // scaled currents, truncated toward zero; all zero while locked
  logic [WN-1:0][15:0] drv_nxt;
  logic [31:0]         fz;
  logic                ov_r;
  logic [15:0]         sf_r;
  logic [WN-1:0][15:0] drv_r;

  always_comb begin
    logic [16:0]    m;
    logic [PRW-1:0] prod;
    logic [16:0]    mg;
    logic [16:0]    dn;
    fz = 32'(cf_r);
    for (int i = 0; i < WN; i++) begin
      m    = ccurr_r[i][15] ? 17'(-{ccurr_r[i][15], ccurr_r[i]}) : {1'b0, ccurr_r[i]};
      prod = PRW'(m) * PRW'(cf_r);
      mg   = prod[FRAC +: 17];
      dn   = ccurr_r[i][15] ? 17'(-mg) : mg;
      drv_nxt[i] = locked ? 16'd0 : dn[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= cv_r;
    end
  end

  always_ff @(posedge clk) begin
    sf_r  <= fz[15:0];
    drv_r <= drv_nxt;
  end

  assign out_v   = ov_r;
  assign out_sf  = sf_r;
  assign out_drv = drv_r;

endmodule

### hdl/wheel_power_limit_scaler.sv
`timescale 1ns / 1ps
// chassis power limiter for four driven wheels
// input channel: an item (four currents, four speeds, limit, capacitor voltage,
//   capacitor flag, measured power) is taken on a clock edge with start high
//   and busy low; a new item may follow on every cycle
// result channel: out_valid is high for one cycle with the scale factor and
//   the four scaled currents; the receiver has no way to hold results off
// path: every item passes the same registers from the accepting edge to
//   the cycle with out_valid, and nothing stalls it on the way
// throughput: one item per cycle while busy is low; the divider is pipelined
//   one quotient bit per stage and each wheel has its own power pipeline
// front: captures the item, adjusts the limit, computes the correction term
// queue: two entries between front and back; the back drains it every cycle,
//   so busy stays low in practice
// back: wheel power estimate, limit / estimate division, clamping, scaling
// config: cfg_we writes cfg_wdata into motors_locked, which forces all drive
//   outputs to zero; write it only while nothing is in flight
// reset: synchronous, active low; empties all pipelines and sets motors_locked
module wheel_power_limit_scaler #(
  parameter int FACTOR_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_current_front_left,
  input  logic signed [15:0] in_current_front_right,
  input  logic signed [15:0] in_current_back_left,
  input  logic signed [15:0] in_current_back_right,
  input  logic signed [15:0] in_speed_front_left,
  input  logic signed [15:0] in_speed_front_right,
  input  logic signed [15:0] in_speed_back_left,
  input  logic signed [15:0] in_speed_back_right,
  input  logic [9:0]         in_power_limit_watts,
  input  logic [8:0]         in_cap_voltage_decivolts,
  input  logic               in_cap_not_full,
  input  logic [15:0]        in_measured_power,
  output logic               out_valid,
  output logic [15:0]        out_scale_factor,
  output logic signed [15:0] out_drive_front_left,
  output logic signed [15:0] out_drive_front_right,
  output logic signed [15:0] out_drive_back_left,
  output logic signed [15:0] out_drive_back_right,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  localparam int CW  = FACTOR_FRAC_BITS + 1;
  localparam int QW  = $bits(wpls_pkg::cls_t) + CW;
  localparam int LAT = FACTOR_FRAC_BITS + 14;

  // lock register
  logic motors_locked_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motors_locked_r <= 1'b1;
    end else if (cfg_we) begin
      motors_locked_r <= cfg_wdata;
    end
  end

  // gather per wheel fields, front left first
  logic [wpls_pkg::WHEELS-1:0][15:0] curr, speed;
  logic                              acc;

  assign curr  = {in_current_back_right, in_current_back_left,
                  in_current_front_right, in_current_front_left};
  assign speed = {in_speed_back_right, in_speed_back_left,
                  in_speed_front_right, in_speed_front_left};
  assign acc   = start && !busy;

  // front
  logic                    f_v;
  wpls_pkg::cls_t          f_cls;
  logic signed [CW-1:0]    f_corr;

  wpls_front #(
    .FRAC (FACTOR_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .curr     (curr),
    .speed    (speed),
    .lim      (in_power_limit_watts),
    .volt     (in_cap_voltage_decivolts),
    .cap_nf   (in_cap_not_full),
    .meas     (in_measured_power),
    .out_v    (f_v),
    .out_cls  (f_cls),
    .out_corr (f_corr)
  );

  // queue between front and back
  logic [QW-1:0]         q_rdata;
  logic                  q_empty, q_full;
  wpls_pkg::cls_t        b_cls;
  logic signed [CW-1:0]  b_corr;

  wpls_queue #(
    .W     (QW),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_v),
    .wdata ({f_corr, f_cls}),
    .pop   (!q_empty),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  assign {b_corr, b_cls} = q_rdata;
  assign busy = q_full;

  // back
  logic [wpls_pkg::WHEELS-1:0][15:0] drv;

  wpls_back #(
    .FRAC (FACTOR_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (!q_empty),
    .in_cls  (b_cls),
    .in_corr (b_corr),
    .locked  (motors_locked_r),
    .out_v   (out_valid),
    .out_sf  (out_scale_factor),
    .out_drv (drv)
  );

  assign out_drive_front_left  = drv[0];
  assign out_drive_front_right = drv[1];
  assign out_drive_back_left   = drv[2];
  assign out_drive_back_right  = drv[3];

  // queue never backs up since the back drains it every cycle
  assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("queue filled up");

  // fixed latency from accept to result
  assert property (@(posedge clk) disable iff (!rst_n) acc |-> ##LAT out_valid)
    else $error("result missing at expected latency");

  // a locked block drives no current
  assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && $past(motors_locked_r) |->
      (drv[0] == 16'd0) && (drv[1] == 16'd0) && (drv[2] == 16'd0) && (drv[3] == 16'd0))
    else $error("drive nonzero while locked");

endmodule

### test/wheel_power_limit_scaler_test.sv
`timescale 1ns / 1ps
module wheel_power_limit_scaler_test;

  // one item as driven on the input ports
  typedef struct {
    logic signed [15:0] curr [4];
    logic signed [15:0] spd [4];
    logic [9:0]  lim;
    logic [8:0]  volt;
    logic        notfull;
    logic [15:0] meas;
  } wheel_item_t;

  // one result as seen on the output ports
  typedef struct {
    logic [15:0] factor;
    logic [15:0] drive [4];
  } drive_result_t;

  // quadratic power model of one wheel, magnitude rounded to q16.16
  function automatic longint unsigned wheel_watts(longint s, longint c);
    longint t;
    longint unsigned m;
    t = 64'sd537355092940 - 64'sd322804581 * s + 64'sd58539471 * c
      + 64'sd219902 * s * s + 64'sd2242849 * s * c + 64'sd137439 * c * c;
    m = (t < 0) ? longint'(-t) : t;
    return (m + (64'd1 << 23)) >> 24;
  endfunction

  function automatic longint scale_for(wheel_item_t it);
    longint one, lim, volt, meas, lq, f, err, corr, cmax;
    longint unsigned est, mag, em, den;
    one = 64'sd32768;
    lim = it.lim;
    volt = it.volt;
    meas = it.meas;
    est = 0;
    if (lim == 0) return one;
    if (volt <= 120 || it.notfull) begin
      lim -= 2;
      if (volt <= 100) lim -= 2;
      if (volt <= 80) lim -= 4;
    end else begin
      lim += volt;
    end
    for (int i = 0; i < 4; i++) est += wheel_watts(it.spd[i], it.curr[i]);
    if (est == 0) return one;
    lq = lim * 65536;
    mag = ((lq < 0) ? longint'(-lq) : lq) << 15;
    f = longint'(mag / est);
    if (lq < 0) f = -f;
    if (3 * meas * 4096 >= lq) begin
      err = lq - meas * 4096;
      den = 64'd6553600;
      em = ((err < 0) ? longint'(-err) : err) << 15;
      corr = longint'((em + den / 2) / den);
      if (err < 0) corr = -corr;
      cmax = (one + 5) / 10;
      if (corr > cmax) corr = cmax;
      if (corr < -cmax) corr = -cmax;
      f += corr;
    end
    if (f < 0) f = 0;
    if (f > one) f = one;
    return f;
  endfunction

  class drive_scoreboard;
    drive_result_t pending [$];
    bit locked = 1;
    int errors = 0;
    int checked = 0;

    function void note_item(wheel_item_t it);
      drive_result_t r;
      longint f, c, d;
      longint unsigned m;
      f = scale_for(it);
      r.factor = f[15:0];
      for (int i = 0; i < 4; i++) begin
        c = it.curr[i];
        d = 0;
        if (!locked) begin
          m = (c < 0) ? longint'(-c) : c;
          d = longint'((m * f) >> 15);
          if (c < 0) d = -d;
        end
        r.drive[i] = d[15:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(drive_result_t got);
      drive_result_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result factor %h", $time, got.factor);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.factor !== want.factor) begin
        $display("%0t factor expected %h actual %h", $time, want.factor, got.factor);
        errors++;
      end
      for (int i = 0; i < 4; i++)
        if (got.drive[i] !== want.drive[i]) begin
          $display("%0t drive %0d expected %h actual %h", $time, i,
                   want.drive[i], got.drive[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [15:0] cur_fl = 0, cur_fr = 0, cur_bl = 0, cur_br = 0;
  logic signed [15:0] spd_fl = 0, spd_fr = 0, spd_bl = 0, spd_br = 0;
  logic [9:0]  lim_w = 0;
  logic [8:0]  volt_dv = 0;
  logic        cap_nf = 0;
  logic [15:0] meas_pw = 0;
  logic        out_valid;
  logic [15:0] out_factor;
  logic signed [15:0] drv_fl, drv_fr, drv_bl, drv_br;
  logic cfg_we = 0;
  logic cfg_wdata = 0;

  drive_scoreboard sb;
  int sent = 0;

  always #2 clk = ~clk;

  wheel_power_limit_scaler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_current_front_left(cur_fl), .in_current_front_right(cur_fr),
    .in_current_back_left(cur_bl), .in_current_back_right(cur_br),
    .in_speed_front_left(spd_fl), .in_speed_front_right(spd_fr),
    .in_speed_back_left(spd_bl), .in_speed_back_right(spd_br),
    .in_power_limit_watts(lim_w), .in_cap_voltage_decivolts(volt_dv),
    .in_cap_not_full(cap_nf), .in_measured_power(meas_pw),
    .out_valid(out_valid), .out_scale_factor(out_factor),
    .out_drive_front_left(drv_fl), .out_drive_front_right(drv_fr),
    .out_drive_back_left(drv_bl), .out_drive_back_right(drv_br),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // results cannot be held off, so every strobe is checked at the edge
  always @(posedge clk) begin
    drive_result_t got;
    if (rst_n && out_valid) begin
      got.factor = out_factor;
      got.drive[0] = drv_fl;
      got.drive[1] = drv_fr;
      got.drive[2] = drv_bl;
      got.drive[3] = drv_br;
      sb.check_result(got);
    end
  end

  // drive one item and hold it until the block takes it; start stays high
  // and the caller drops it
  task automatic send_item(wheel_item_t it);
    start <= 1;
    cur_fl <= it.curr[0]; cur_fr <= it.curr[1];
    cur_bl <= it.curr[2]; cur_br <= it.curr[3];
    spd_fl <= it.spd[0]; spd_fr <= it.spd[1];
    spd_bl <= it.spd[2]; spd_br <= it.spd[3];
    lim_w <= it.lim; volt_dv <= it.volt;
    cap_nf <= it.notfull; meas_pw <= it.meas;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
    sent++;
  endtask

  // random gap, mostly none or short, now and then long
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // drop start, wait for every expected result, then let the clock run idle
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic write_lock(bit v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.locked = v;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_current();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic wheel_item_t rand_item();
    wheel_item_t it;
    for (int i = 0; i < 4; i++) begin
      it.curr[i] = rand_current();
      it.spd[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                : 16'($signed($urandom_range(0, 16000)) - 8000);
    end
    it.lim = ($urandom_range(0, 9) == 0) ? 10'd0 :
             ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(1, 200));
    it.volt = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 300));
    it.notfull = 1'($urandom_range(0, 1));
    it.meas = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
    return it;
  endfunction

  function automatic wheel_item_t flat_item(logic signed [15:0] c, logic signed [15:0] s,
                                            int lim, int volt, bit nf, int meas);
    wheel_item_t it;
    for (int i = 0; i < 4; i++) begin
      it.curr[i] = c;
      it.spd[i] = s;
    end
    it.lim = 10'(lim); it.volt = 9'(volt); it.notfull = nf; it.meas = 16'(meas);
    return it;
  endfunction

  initial begin
    wheel_item_t it;
    wheel_item_t dir [$];
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed items: field extremes, each limit adjustment band, special cases
    dir.push_back(flat_item(16384, 32767, 0, 300, 0, 65535));     // zero limit
    dir.push_back(flat_item(0, 0, 1, 0, 1, 0));                   // negative limit
    dir.push_back(flat_item(-16384, -32768, 1023, 300, 0, 0));
    dir.push_back(flat_item(16384, 32767, 1023, 121, 0, 65535));  // voltage bonus
    dir.push_back(flat_item(8000, 2000, 80, 120, 0, 1000));
    dir.push_back(flat_item(8000, 2000, 80, 100, 0, 1000));
    dir.push_back(flat_item(8000, 2000, 80, 80, 0, 1000));
    dir.push_back(flat_item(8000, 2000, 80, 250, 1, 1000));       // not full
    dir.push_back(flat_item(-8000, 2000, 60, 200, 0, 65535));     // correction down
    dir.push_back(flat_item(-8000, -2000, 60, 200, 0, 300));      // no correction, measured power low
    dir.push_back(flat_item(100, 10, 500, 300, 0, 0));            // factor clamps high
    dir.push_back(flat_item(16'h7fff, 16'h7fff, 10'h3ff, 9'h1ff, 1, 16'hffff));
    dir.push_back(flat_item(16'h8000, 16'h8000, 1, 9'h1ff, 0, 0));
    dir.push_back(flat_item(-1, 1, 40, 150, 0, 213));
    // start drops between items
    foreach (dir[k]) begin
      send_item(dir[k]);
      start <= 0;
      @(posedge clk);
    end
    drain();

    // the same items back to back
    write_lock(0);
    foreach (dir[k]) send_item(dir[k]);
    drain();

    // random phases, every third one locked
    for (int ph = 0; ph < 6; ph++) begin
      write_lock(ph % 3 != 2 ? 0 : 1);
      for (int n = 0; n < 100; n++) begin
        it = rand_item();
        send_item(it);
        if (n == 50 || n == 99) drain();
        else idle_gap();
      end
    end

    $display("sent %0d items through %0d random phases, %0d results checked",
             sent, 6, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
hdl/wpls_pkg.sv
hdl/wpls_front.sv
hdl/wpls_queue.sv
hdl/wpls_wheel.sv
hdl/wpls_div.sv
hdl/wpls_back.sv
hdl/wheel_power_limit_scaler.sv
test/wheel_power_limit_scaler_test.sv
